@@ src/pcfs_pkg.sv @@
// shared types and constants for the png chunk color flag scanner
package pcfs_pkg;

   // png file signature, first byte at index 0
   localparam logic [7:0] SIG_BYTES [8] = '{
      8'h89, 8'h50, 8'h4e, 8'h47, 8'h0d, 8'h0a, 8'h1a, 8'h0a
   };

   // chunk type codes as they arrive, big-endian
   localparam logic [31:0] TYPE_ICCP = 32'h6943_4350;
   localparam logic [31:0] TYPE_SRGB = 32'h7352_4742;
   localparam logic [31:0] TYPE_CHRM = 32'h6348_524d;
   localparam logic [31:0] TYPE_GAMA = 32'h6741_4d41;

   // length, type and crc bytes around the chunk data
   localparam logic [32:0] CHUNK_OVERHEAD = 33'd12;
   localparam logic [4:0]  MIN_TOTAL      = 5'd20;
   localparam logic [4:0]  TOTAL_SAT      = 5'd31;

   // one byte of the file as held in the input register
   typedef struct packed {
      logic       last_byte;
      logic [7:0] data_byte;
   } byte_type;

   // one result of a scanned file
   typedef struct packed {
      logic has_gamma;
      logic has_chromaticity;
      logic has_srgb_chunk;
      logic has_icc;
      logic valid_res;
   } result_type;

endpackage

@@ src/pcfs_walker.sv @@
// signature check and chunk walk state with its per-byte update
module pcfs_walker (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  pcfs_pkg::byte_type    byte_in,
   output pcfs_pkg::result_type  result
);

   localparam logic PHASE_SIG   = 1'b0;
   localparam logic PHASE_CHUNK = 1'b1;

   localparam int FLAG_ICC  = 0;
   localparam int FLAG_SRGB = 1;
   localparam int FLAG_CHRM = 2;
   localparam int FLAG_GAMA = 3;

   logic        phase_ff,   phase_in;
   logic [2:0]  sig_idx_ff, sig_idx_in;
   logic [32:0] count_ff,   count_in;
   logic [31:0] length_ff,  length_in;
   logic [31:0] type_ff,    type_in;
   logic [3:0]  flags_ff,   flags_in;
   logic        error_ff,   error_in;
   logic [4:0]  total_ff,   total_in;

   logic [32:0] count_inc;
   logic [32:0] chunk_end;
   logic        file_ok;

   always_comb begin
      phase_in   = phase_ff;
      sig_idx_in = sig_idx_ff;
      count_in   = count_ff;
      length_in  = length_ff;
      type_in    = type_ff;
      flags_in   = flags_ff;
      error_in   = error_ff;
      total_in   = (total_ff == pcfs_pkg::TOTAL_SAT) ? total_ff : total_ff + 5'd1;
      count_inc  = count_ff + 33'd1;
      chunk_end  = {1'b0, length_ff} + pcfs_pkg::CHUNK_OVERHEAD;

      unique case (phase_ff)
         PHASE_SIG: begin
            if (byte_in.data_byte != pcfs_pkg::SIG_BYTES[sig_idx_ff]) begin
               error_in = 1'b1;
            end
            sig_idx_in = sig_idx_ff + 3'd1;
            if (sig_idx_ff == 3'd7) begin
               phase_in = PHASE_CHUNK;
            end
         end
         PHASE_CHUNK: begin
            if (count_ff < 33'd4) begin
               length_in = {length_ff[23:0], byte_in.data_byte};
            end else if (count_ff < 33'd8) begin
               type_in = {type_ff[23:0], byte_in.data_byte};
            end
            count_in = count_inc;
            if (count_inc == pcfs_pkg::CHUNK_OVERHEAD) begin
               if (type_ff == pcfs_pkg::TYPE_ICCP) flags_in[FLAG_ICC]  = 1'b1;
               if (type_ff == pcfs_pkg::TYPE_SRGB) flags_in[FLAG_SRGB] = 1'b1;
               if (type_ff == pcfs_pkg::TYPE_CHRM) flags_in[FLAG_CHRM] = 1'b1;
               if (type_ff == pcfs_pkg::TYPE_GAMA) flags_in[FLAG_GAMA] = 1'b1;
            end
            // length bytes are settled long before the end of a chunk
            if (count_inc >= pcfs_pkg::CHUNK_OVERHEAD && count_inc == chunk_end) begin
               count_in  = '0;
               length_in = '0;
               type_in   = '0;
            end
         end
         default: begin
            phase_in = PHASE_SIG;
         end
      endcase

      file_ok = !error_in && (total_in >= pcfs_pkg::MIN_TOTAL) &&
                (phase_in == PHASE_CHUNK) && (count_in < pcfs_pkg::CHUNK_OVERHEAD);

      result.valid_res        = file_ok;
      result.has_icc          = file_ok & flags_in[FLAG_ICC];
      result.has_srgb_chunk   = file_ok & flags_in[FLAG_SRGB];
      result.has_chromaticity = file_ok & flags_in[FLAG_CHRM];
      result.has_gamma        = file_ok & flags_in[FLAG_GAMA];
   end

   always_ff @(posedge clock) begin
      if (reset || (step && byte_in.last_byte)) begin
         phase_ff   <= PHASE_SIG;
         sig_idx_ff <= '0;
         count_ff   <= '0;
         length_ff  <= '0;
         type_ff    <= '0;
         flags_ff   <= '0;
         error_ff   <= 1'b0;
         total_ff   <= '0;
      end else if (step) begin
         phase_ff   <= phase_in;
         sig_idx_ff <= sig_idx_in;
         count_ff   <= count_in;
         length_ff  <= length_in;
         type_ff    <= type_in;
         flags_ff   <= flags_in;
         error_ff   <= error_in;
         total_ff   <= total_in;
      end
   end

endmodule

@@ src/png_chunk_color_flag_scanner.sv @@
// top level of the png chunk color flag scanner
//
// usage
//   the req channel carries a png file one byte per transfer, req_tlast on
//   the final byte. the scanner checks the 8-byte signature, walks the chunks
//   (length, type, data, crc) and notes iCCP, sRGB, cHRM and gAMA chunks.
//   for each file one transfer leaves on the rsp channel, taken at the last
//   byte: valid_res plus four flags, flags forced to zero when not valid.
// throughput and pipeline
//   one byte per cycle sustained, unless a last byte is held (see stalls). a byte
//   lands in the input register and is folded into the walk state when it steps
//   out; that same edge loads the result register, which drives rsp_tvalid.
// reset
//   synchronous reset empties the input and result registers and returns
//   the walker to the start of a file. the walker also restarts by itself
//   after every last byte, ready for the next file with no gap.
// stalls
//   while a result waits on rsp_tready, ordinary bytes keep flowing; only a
//   next last byte holds in the input register and drops req_tready.
module png_chunk_color_flag_scanner (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // last_byte
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] valid_res, [1] has_icc, [2] has_srgb_chunk,
                                   // [3] has_chromaticity, [4] has_gamma, [7:5] zero
);

   // input register
   logic                 in_valid_ff, in_valid_in;
   pcfs_pkg::byte_type   in_byte_ff;

   // result register
   logic                 rsp_valid_ff, rsp_valid_in;
   pcfs_pkg::result_type rsp_data_ff;

   pcfs_pkg::result_type walk_result;
   logic                 advance;
   logic                 step;

   // a held byte moves on unless it would emit a result into a full,
   // stalled result register
   assign advance    = !in_byte_ff.last_byte || !rsp_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;

   assign in_valid_in  = (req_tvalid && req_tready) ? 1'b1 : (step ? 1'b0 : in_valid_ff);
   assign rsp_valid_in = (step && in_byte_ff.last_byte) ? 1'b1 :
                         (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff.data_byte <= req_tdata;
         in_byte_ff.last_byte <= req_tlast;
      end
      if (step && in_byte_ff.last_byte) begin
         rsp_data_ff <= walk_result;
      end
   end

   // signature and chunk walk
   pcfs_walker u_walker (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .byte_in (in_byte_ff),
      .result  (walk_result)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_data_ff};

`ifndef NO_ASSERTIONS
   // an invalid file never reports a chunk flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[4:1] == 4'b0000)
      else $error("flags set on an invalid file result");

   // input side only stalls on a held last byte behind a waiting result
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> in_valid_ff && in_byte_ff.last_byte && rsp_valid_ff && !rsp_tready)
      else $error("input stalled without a pending result");

   // a result appears only after a last byte went through the walker
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(step) && $past(in_byte_ff.last_byte))
      else $error("result without a last byte");
`endif

endmodule

@@ tb/tb_png_chunk_color_flag_scanner.sv @@
// self-checking testbench for the png chunk color flag scanner
module tb_png_chunk_color_flag_scanner;
   timeunit 1ns;
   timeprecision 1ps;

   // walk phases of the scanner
   typedef enum logic [1:0] {
      WALK_SIGNATURE = 2'd0,
      WALK_CHUNKS    = 2'd1
   } walk_phase_type;

   // an ordinary chunk type that sets no flag
   localparam logic [31:0] TYPE_IDAT = 32'h4944_4154;

   // cycles with no transfer on either channel before the run is given up;
   // the longest honest quiet stretch is a sender gap or a receiver stall at
   // 48 percent idling plus the wait through the result register, far below this
   localparam int QUIET_LIMIT = 2000;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] data_byte
   logic       req_tlast = 1'b0;    // last_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [0] valid_res, [1] has_icc, [2] has_srgb_chunk,
                                    // [3] has_chromaticity, [4] has_gamma, [7:5] zero

   // idling in percent of cycles, changed per test phase
   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned fault_count = 0;
   int unsigned quiet_cycles = 0;
   int unsigned bytes_sent = 0;

   // flag results predicted for files whose last byte has been accepted
   pcfs_pkg::result_type file_results[$];

   // bytes of the file under construction
   logic [7:0] file_bytes[$];

   // predicted walk state
   walk_phase_type walk_phase;
   logic [3:0]  sig_pos;
   logic [32:0] chunk_pos;
   logic [31:0] chunk_len;
   logic [31:0] chunk_kind;
   logic [3:0]  color_seen;    // bit0 iCCP, bit1 sRGB, bit2 cHRM, bit3 gAMA
   logic        sig_broken;
   logic [4:0]  byte_total;

   png_chunk_color_flag_scanner i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // prediction of the scanner
   // ---------------------------------------------------------------------

   function automatic void restart_walk();
      walk_phase = WALK_SIGNATURE;
      sig_pos    = '0;
      chunk_pos  = '0;
      chunk_len  = '0;
      chunk_kind = '0;
      color_seen = '0;
      sig_broken = 1'b0;
      byte_total = '0;
   endfunction

   // fold one accepted byte into the walk; a last byte yields the file result
   function automatic void scan_byte(input logic [7:0] value, input logic is_last);
      pcfs_pkg::result_type res;
      logic                 sound;
      if (byte_total < pcfs_pkg::TOTAL_SAT)
         byte_total = byte_total + 5'd1;
      if (walk_phase == WALK_SIGNATURE) begin
         if (value != pcfs_pkg::SIG_BYTES[sig_pos[2:0]])
            sig_broken = 1'b1;
         sig_pos = sig_pos + 4'd1;
         if (sig_pos >= 4'd8)
            walk_phase = WALK_CHUNKS;
      end else begin
         // big-endian length, then type; data and crc only advance the count
         if (chunk_pos < 33'd4)
            chunk_len = {chunk_len[23:0], value};
         else if (chunk_pos < 33'd8)
            chunk_kind = {chunk_kind[23:0], value};
         chunk_pos = chunk_pos + 33'd1;
         // the type counts once the 12th byte of the chunk is in
         if (chunk_pos == pcfs_pkg::CHUNK_OVERHEAD) begin
            case (chunk_kind)
               pcfs_pkg::TYPE_ICCP: color_seen[0] = 1'b1;
               pcfs_pkg::TYPE_SRGB: color_seen[1] = 1'b1;
               pcfs_pkg::TYPE_CHRM: color_seen[2] = 1'b1;
               pcfs_pkg::TYPE_GAMA: color_seen[3] = 1'b1;
               default: ;
            endcase
         end
         // chunk complete: next byte starts a new length field
         if (chunk_pos >= pcfs_pkg::CHUNK_OVERHEAD &&
             chunk_pos == {1'b0, chunk_len} + pcfs_pkg::CHUNK_OVERHEAD) begin
            chunk_pos  = '0;
            chunk_len  = '0;
            chunk_kind = '0;
         end
      end
      if (is_last) begin
         // a tail under 12 bytes is ignored, a longer cut chunk spoils the file
         sound = !sig_broken && byte_total >= pcfs_pkg::MIN_TOTAL &&
                 walk_phase == WALK_CHUNKS && chunk_pos < pcfs_pkg::CHUNK_OVERHEAD;
         res.valid_res        = sound;
         res.has_icc          = sound & color_seen[0];
         res.has_srgb_chunk   = sound & color_seen[1];
         res.has_chromaticity = sound & color_seen[2];
         res.has_gamma        = sound & color_seen[3];
         file_results.push_back(res);
         restart_walk();
      end
   endfunction

   // ---------------------------------------------------------------------
   // file construction
   // ---------------------------------------------------------------------

   function automatic void put_word(input logic [31:0] word);
      for (int i = 3; i >= 0; i--)
         file_bytes.push_back(word[8*i +: 8]);
   endfunction

   function automatic void put_noise(input int unsigned count);
      repeat (count) file_bytes.push_back(8'($urandom_range(255)));
   endfunction

   // png signature, one byte spoiled when bad_pos is 0 to 7
   function automatic void put_signature(input int bad_pos);
      for (int i = 0; i < 8; i++) begin
         if (i == bad_pos)
            file_bytes.push_back(pcfs_pkg::SIG_BYTES[i] ^ 8'($urandom_range(1, 255)));
         else
            file_bytes.push_back(pcfs_pkg::SIG_BYTES[i]);
      end
   endfunction

   // complete chunk with random data and crc
   function automatic void put_chunk(input logic [31:0] kind, input int unsigned len);
      put_word(len);
      put_word(kind);
      put_noise(len);
      put_word($urandom);
   endfunction

   // ---------------------------------------------------------------------
   // req side: one byte per transfer, driven on the falling edge
   // ---------------------------------------------------------------------

   // called and returning on a falling edge; tvalid stays high across
   // back-to-back bytes and only drops for a sender gap
   task automatic send_byte(input logic [7:0] value, input logic is_last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      scan_byte(value, is_last);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_file();
      int unsigned n;
      n = file_bytes.size();
      for (int unsigned i = 0; i < n; i++)
         send_byte(file_bytes[i], i == n - 1);
      file_bytes.delete();
   endtask

   // ---------------------------------------------------------------------
   // rsp side: random stalls and result checking
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_results
      string                field_names [5];
      pcfs_pkg::result_type want;
      pcfs_pkg::result_type got;
      field_names = '{"valid_res", "has_icc", "has_srgb_chunk",
                      "has_chromaticity", "has_gamma"};
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[4:0];
         if (file_results.size() == 0) begin
            $error("result transfer with no file pending: rsp_tdata %h", rsp_tdata);
            fault_count++;
         end else begin
            want = file_results.pop_front();
            // result_type bits follow the rsp_tdata field order
            for (int i = 0; i < 5; i++) begin
               if (want[i] !== got[i]) begin
                  $error("%s: expected %0b, got %0b", field_names[i], want[i], got[i]);
                  fault_count++;
               end
            end
         end
      end
   end

   // watchdog on cycles with no transfer at all
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("png_chunk_color_flag_scanner: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // hand-built files around each corner of the chunk walk
   task automatic test_known_files();
      // every color chunk, each with no data
      put_signature(-1);
      put_chunk(pcfs_pkg::TYPE_ICCP, 0);
      put_chunk(pcfs_pkg::TYPE_SRGB, 0);
      put_chunk(pcfs_pkg::TYPE_CHRM, 0);
      put_chunk(pcfs_pkg::TYPE_GAMA, 0);
      send_file();
      // data bytes at both extremes, then one color chunk
      put_signature(-1);
      put_word(32'd2);
      put_word(TYPE_IDAT);
      file_bytes.push_back(8'h00);
      file_bytes.push_back(8'hff);
      put_word(32'hffff_ffff);
      put_chunk(pcfs_pkg::TYPE_SRGB, 1);
      send_file();
      // bad signature hides an otherwise good gAMA
      put_signature(3);
      put_chunk(pcfs_pkg::TYPE_GAMA, 0);
      send_file();
      // 19 bytes: one short of the minimum file
      put_signature(-1);
      put_noise(11);
      send_file();
      // smallest sound file: signature plus an empty chunk
      put_signature(-1);
      put_chunk(pcfs_pkg::TYPE_CHRM, 0);
      send_file();
      // chunk cut on exactly its 12th byte
      put_signature(-1);
      put_word(32'd4);
      put_word(pcfs_pkg::TYPE_GAMA);
      put_noise(4);
      send_file();
      // 11-byte tail after a full chunk is ignored, its iCCP type too
      put_signature(-1);
      put_chunk(pcfs_pkg::TYPE_SRGB, 3);
      put_word(32'd0);
      put_word(pcfs_pkg::TYPE_ICCP);
      put_noise(3);
      send_file();
      // a file of one byte
      file_bytes.push_back(pcfs_pkg::SIG_BYTES[0]);
      send_file();
      // largest length, file ends four bytes into the chunk data
      put_signature(-1);
      put_word(32'hffff_ffff);
      put_word(pcfs_pkg::TYPE_CHRM);
      put_word(32'd0);
      send_file();
      // one case bit off from gAMA does not count
      put_signature(-1);
      put_chunk(pcfs_pkg::TYPE_GAMA ^ 32'h0000_0020, 0);
      put_chunk(pcfs_pkg::TYPE_ICCP, 1);
      send_file();
   endtask

   // mostly well-formed files with random chunks and endings, some noise
   task automatic send_random_file();
      int unsigned style;
      int unsigned pick;
      int unsigned len;
      logic [31:0] kind;
      style = $urandom_range(99);
      if (style < 10) begin
         put_noise($urandom_range(1, 24));
      end else begin
         put_signature(($urandom_range(9) == 0) ? int'($urandom_range(7)) : -1);
         repeat ($urandom_range(3)) begin
            pick = $urandom_range(7);
            case (pick)
               0: kind = pcfs_pkg::TYPE_ICCP;
               1: kind = pcfs_pkg::TYPE_SRGB;
               2: kind = pcfs_pkg::TYPE_CHRM;
               3: kind = pcfs_pkg::TYPE_GAMA;
               4, 5: kind = $urandom;
               default: kind = (($urandom_range(1)) ? pcfs_pkg::TYPE_GAMA
                                                    : pcfs_pkg::TYPE_ICCP)
                               ^ (32'd1 << $urandom_range(31));
            endcase
            len = ($urandom_range(15) == 0) ? $urandom_range(7, 40) : $urandom_range(6);
            put_chunk(kind, len);
         end
         pick = $urandom_range(9);
         if (pick < 2) begin
            // short tail, ignored
            put_noise($urandom_range(1, 11));
         end else if (pick < 4) begin
            // chunk cut after its 12th byte or later
            len = ($urandom_range(3) == 0) ? $urandom_range(9, 32'hffff_ffff)
                                           : $urandom_range(1, 8);
            put_word(len);
            put_word(($urandom_range(1)) ? pcfs_pkg::TYPE_SRGB : 32'($urandom));
            put_noise($urandom_range(4, (len > 7) ? 10 : len + 3));
         end
      end
      send_file();
   endtask

   task automatic run_random_files(input int unsigned byte_budget);
      int unsigned start;
      start = bytes_sent;
      while (bytes_sent - start < byte_budget)
         send_random_file();
   endtask

   task automatic test_no_idling();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random_files(370);
   endtask

   task automatic test_sender_idle();
      send_idle_pct  = 48;
      recv_stall_pct = 0;
      run_random_files(370);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct  = 0;
      recv_stall_pct = 48;
      run_random_files(370);
   endtask

   task automatic test_both_idle();
      send_idle_pct  = 31;
      recv_stall_pct = 31;
      run_random_files(370);
   endtask

   // ---------------------------------------------------------------------
   // sequence
   // ---------------------------------------------------------------------

   initial begin
      restart_walk();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_known_files();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();

      req_tvalid <= 1'b0;
      // drain outstanding results; the watchdog bounds this wait
      while (file_results.size() != 0)
         @(posedge clock);
      // wait through the result register, plus margin for any stray transfer
      repeat (8) @(posedge clock);

      if (file_results.size() != 0) begin
         $error("%0d file results never arrived", file_results.size());
         fault_count++;
      end
      if (fault_count == 0) begin
         $display("png_chunk_color_flag_scanner: match");
      end else begin
         $display("png_chunk_color_flag_scanner: mismatch");
      end
      $finish;
   end

endmodule

@@ sim.f @@
src/pcfs_pkg.sv
src/pcfs_walker.sv
src/png_chunk_color_flag_scanner.sv
tb/tb_png_chunk_color_flag_scanner.sv
